// ----- hdl/pdm_cic_decimator_defines.svh -----
// Assertion macros shared by the PDM CIC decimator RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef PDM_CIC_DECIMATOR_DEFINES_SVH
`define PDM_CIC_DECIMATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PCD_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pcd_pkg.sv -----
// Shared types and constants of the PDM CIC decimator.
// No dependencies.
`default_nettype none

package pcd_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CFG_W    = 16;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [CFG_W-1:0]    blk_len_t;

  localparam blk_len_t BLOCK_LEN_RESET = blk_len_t'(256);

endpackage

`default_nettype wire

// ----- hdl/pcd_ifs.sv -----
// Valid/ready channel interfaces of the PDM CIC decimator.
// Depends on pcd_pkg for the sample and block length types.
`default_nettype none

interface pcd_word_if #(
  parameter int unsigned W = 16
);
  logic         valid;
  logic         ready;
  logic [W-1:0] pdm_word;

  modport source (output valid, output pdm_word, input ready);
  modport sink   (input valid, input pdm_word, output ready);
endinterface

interface pcd_pcm_if;
  logic             valid;
  logic             ready;
  pcd_pkg::sample_t pcm_sample;
  logic             block_end;

  modport source (output valid, output pcm_sample, output block_end, input ready);
  modport sink   (input valid, input pcm_sample, input block_end, output ready);
endinterface

interface pcd_cfg_if;
  logic              valid;
  logic              ready;
  pcd_pkg::blk_len_t block_length;

  modport source (output valid, output block_length, input ready);
  modport sink   (input valid, input block_length, output ready);
endinterface

`default_nettype wire

// ----- hdl/pcd_front.sv -----
// Front end: accepts PDM words and holds them in a two-entry queue.
// Depends on pcd_word_if and the assertion macro header.
`default_nettype none
`include "pdm_cic_decimator_defines.svh"

module pcd_front (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  pcd_word_if.sink     in_i,
  pcd_word_if.source   out_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [$bits(in_i.pdm_word)-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push;
  logic             pop;

  assign in_i.ready   = (cnt_q != CNT_W'(DEPTH));
  assign out_o.valid  = (cnt_q != '0);
  assign out_o.pdm_word = mem_q[rd_ptr_q];

  assign push = in_i.valid && in_i.ready;
  assign pop  = out_o.valid && out_o.ready;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_i.pdm_word;
    end
  end

  `PCD_ASSERT(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(DEPTH), "queue count exceeds depth")
  `PCD_ASSERT(a_ptr_sync, cnt_q == '0 || cnt_q == CNT_W'(DEPTH), wr_ptr_q == rd_ptr_q,
              "queue pointers diverge at empty or full")

endmodule

`default_nettype wire

// ----- hdl/pcd_engine.sv -----
// Back end: bit-serial integrator cascade, comb chain, block counter, output register.
// Depends on pcd_pkg, the channel interfaces and the assertion macro header.
`default_nettype none
`include "pdm_cic_decimator_defines.svh"

module pcd_engine #(
  parameter int unsigned STAGES        = 4,
  parameter int unsigned BITS_PER_WORD = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pcd_word_if.sink   word_i,
  pcd_cfg_if.sink    cfg_i,
  pcd_pcm_if.source  pcm_o
);

  import pcd_pkg::*;

  localparam int unsigned BIT_CNT_W = $clog2(BITS_PER_WORD);

  logic [BITS_PER_WORD-1:0] word_q, word_d;
  logic [BIT_CNT_W-1:0]     bit_cnt_q, bit_cnt_d;
  logic                     busy_q, busy_d;
  logic                     comb_pend_q, comb_pend_d;

  sample_t sum_q [STAGES];
  sample_t sum_d [STAGES];
  sample_t dly_q [STAGES];
  sample_t dly_d [STAGES];
  sample_t comb_out;

  blk_len_t blk_len_q;
  blk_len_t cnt_q, cnt_d;
  logic [CFG_W:0] cnt_next;
  logic           blk_end;

  logic    out_valid_q;
  sample_t out_sample_q;
  logic    out_end_q;

  logic out_free;
  logic comb_fire;
  logic step;
  logic last_bit;
  logic pop;

  assign out_free  = !out_valid_q || pcm_o.ready;
  assign comb_fire = comb_pend_q && out_free;
  // Integrators feed the comb source, so hold them until a pending sample moves on.
  assign step      = busy_q && (!comb_pend_q || comb_fire);
  assign last_bit  = (bit_cnt_q == BIT_CNT_W'(BITS_PER_WORD - 1));
  assign pop       = !busy_q || (step && last_bit);

  assign word_i.ready = pop;
  assign cfg_i.ready  = 1'b1;

  assign pcm_o.valid      = out_valid_q;
  assign pcm_o.pcm_sample = out_sample_q;
  assign pcm_o.block_end  = out_end_q;

  // One PDM bit through the whole integrator cascade.
  always_comb begin
    sum_d[0] = sum_q[0] + (word_q[BITS_PER_WORD-1] ? sample_t'(1) : '1);
    for (int unsigned s = 1; s < STAGES; s++) begin
      sum_d[s] = sum_q[s] + sum_d[s-1];
    end
  end

  // Comb chain on the registered last integrator.
  always_comb begin
    sample_t x;
    x = sum_q[STAGES-1];
    for (int unsigned s = 0; s < STAGES; s++) begin
      dly_d[s] = x;
      x        = x - dly_q[s];
    end
    comb_out = x;
  end

  always_comb begin
    cnt_next = {1'b0, cnt_q} + (CFG_W+1)'(1);
    blk_end  = (cnt_next >= {1'b0, blk_len_q});
    cnt_d    = blk_end ? '0 : cnt_next[CFG_W-1:0];
  end

  always_comb begin
    word_d      = word_q;
    bit_cnt_d   = bit_cnt_q;
    busy_d      = busy_q;
    comb_pend_d = comb_pend_q;
    if (comb_fire) begin
      comb_pend_d = 1'b0;
    end
    if (step) begin
      word_d = {word_q[BITS_PER_WORD-2:0], 1'b0};
      if (last_bit) begin
        bit_cnt_d   = '0;
        comb_pend_d = 1'b1;
        busy_d      = 1'b0;
      end else begin
        bit_cnt_d = bit_cnt_q + BIT_CNT_W'(1);
      end
    end
    if (pop && word_i.valid) begin
      word_d = word_i.pdm_word;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q   <= '0;
      busy_q      <= 1'b0;
      comb_pend_q <= 1'b0;
      blk_len_q   <= BLOCK_LEN_RESET;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int unsigned s = 0; s < STAGES; s++) begin
        sum_q[s] <= '0;
        dly_q[s] <= '0;
      end
    end else begin
      bit_cnt_q   <= bit_cnt_d;
      busy_q      <= busy_d;
      comb_pend_q <= comb_pend_d;
      if (cfg_i.valid) begin
        blk_len_q <= cfg_i.block_length;
      end
      if (step) begin
        for (int unsigned s = 0; s < STAGES; s++) begin
          sum_q[s] <= sum_d[s];
        end
      end
      if (comb_fire) begin
        for (int unsigned s = 0; s < STAGES; s++) begin
          dly_q[s] <= dly_d[s];
        end
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (pcm_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    if (comb_fire) begin
      out_sample_q <= comb_out;
      out_end_q    <= blk_end;
    end
  end

  `PCD_ASSERT(a_cnt_idle, bit_cnt_q != '0, busy_q, "bit count advanced without a word")
  `PCD_ASSERT_NEXT(a_fire_out, comb_fire, out_valid_q, "fired sample not presented")
  `PCD_ASSERT_NEXT(a_end_cnt, comb_fire, out_end_q == (cnt_q == '0),
                   "block end flag disagrees with sample count")
  `PCD_ASSERT_NEXT(a_pend_hold, comb_pend_q && !out_free, comb_pend_q && $stable(sum_q[STAGES-1]),
                   "pending sample source changed while stalled")

endmodule

`default_nettype wire

// ----- hdl/pdm_cic_decimator.sv -----
// Top level of the PDM CIC decimator: word queue plus integrator/comb engine.
// Depends on pcd_pkg, pcd_ifs, pcd_front and pcd_engine.
//
// Usage:
//   pdm_i carries one word of BITS_PER_WORD PDM bits per request, most
//   significant bit oldest. pcm_o returns exactly one request per word:
//   a 16-bit two's complement PCM sample and block_end, set on the last
//   sample of each block. cfg_i writes block_length (samples per block);
//   its ready is always high and the write takes effect at the next word
//   finished. A length of zero behaves like one.
//   The integrator cascade consumes one PDM bit per cycle unless a pending
//   sample is held by a stalled pcm_o, and takes the next word as it
//   integrates the last bit of the current one. An accepted word passes
//   through the queue, then through the integrator cascade bit by bit, then
//   through the comb chain into the output register that drives pcm_o.valid.
//   A two-entry queue decouples pdm_i from the engine. When pcm_o stalls,
//   the finished sample waits in the output register, the next word still
//   integrates up to its last bit, and the queue fills before pdm_i.ready drops.
//   Reset clears integrators, comb delays and the sample count, and sets
//   block_length to 256.
`default_nettype none

module pdm_cic_decimator #(
  parameter int unsigned STAGES        = 4,
  parameter int unsigned BITS_PER_WORD = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pcd_word_if.sink   pdm_i,
  pcd_cfg_if.sink    cfg_i,
  pcd_pcm_if.source  pcm_o
);

  pcd_word_if #(.W(BITS_PER_WORD)) queue_if ();

  pcd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pdm_i),
    .out_o  (queue_if)
  );

  pcd_engine #(
    .STAGES        (STAGES),
    .BITS_PER_WORD (BITS_PER_WORD)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .word_i (queue_if),
    .cfg_i  (cfg_i),
    .pcm_o  (pcm_o)
  );

endmodule

`default_nettype wire

// ----- sim/pcd_tb_pkg.sv -----
// Scoreboard for the PDM CIC decimator testbench: sample predictor and expected-sample queue.
// Depends on pcd_pkg for the sample and block length types.
`default_nettype none

package pcd_tb_pkg;

  import pcd_pkg::*;

  localparam int unsigned STAGES        = 4;
  localparam int unsigned BITS_PER_WORD = 16;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef logic [BITS_PER_WORD-1:0] pdm_word_t;

  typedef struct packed {
    sample_t pcm_sample;
    logic    block_end;
  } pcm_result_t;

  class pcm_checker;
    sample_t     integ_sum [STAGES];
    sample_t     comb_dly [STAGES];
    blk_len_t    samples_in_block;
    blk_len_t    block_len;
    pcm_result_t pcm_due [$];
    int unsigned miss_count;

    function new();
      foreach (integ_sum[s]) integ_sum[s] = '0;
      foreach (comb_dly[s]) comb_dly[s] = '0;
      samples_in_block = '0;
      block_len        = BLOCK_LEN_RESET;
      miss_count       = 0;
    endfunction

    // The sample count is kept across a length change.
    function void set_block_length(blk_len_t len);
      block_len = len;
    endfunction

    // Integrate the word bit by bit, oldest first, then run the comb chain.
    function void take_word(pdm_word_t word);
      sample_t     x;
      sample_t     y;
      logic [16:0] next_count;
      pcm_result_t res;
      for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
        integ_sum[0] += word[i] ? sample_t'(1) : sample_t'(16'hFFFF);
        for (int s = 1; s < STAGES; s++) integ_sum[s] += integ_sum[s-1];
      end
      x = integ_sum[STAGES-1];
      for (int s = 0; s < STAGES; s++) begin
        y           = x - comb_dly[s];
        comb_dly[s] = x;
        x           = y;
      end
      res.pcm_sample = x;
      // A length of zero, or one already passed, closes the block now.
      next_count = {1'b0, samples_in_block} + 17'd1;
      if (next_count >= {1'b0, block_len}) begin
        res.block_end    = 1'b1;
        samples_in_block = '0;
      end else begin
        res.block_end    = 1'b0;
        samples_in_block = next_count[15:0];
      end
      pcm_due.push_back(res);
    endfunction

    function void report_miss(string what, int unsigned want, int unsigned got);
      if (miss_count < MAX_REPORTS)
        $display("mismatch %s: expected %04h, got %04h", what, want, got);
      miss_count++;
    endfunction

    function void check_pcm(sample_t got_sample, logic got_end);
      pcm_result_t want;
      if (pcm_due.size() == 0) begin
        report_miss("unexpected pcm request", 0, got_sample);
        return;
      end
      want = pcm_due.pop_front();
      if (got_sample !== want.pcm_sample)
        report_miss("pcm_sample", want.pcm_sample, got_sample);
      if (got_end !== want.block_end)
        report_miss("block_end", want.block_end, got_end);
    endfunction

    function int unsigned pending();
      return pcm_due.size();
    endfunction

    function bit clean();
      return miss_count == 0 && pcm_due.size() == 0;
    endfunction
  endclass

endpackage

`default_nettype wire

// ----- sim/tb.sv -----
// Top-level testbench of pdm_cic_decimator: drives words and block lengths, checks each sample.
// Depends on pcd_pkg, pcd_ifs, pcd_tb_pkg and the decimator RTL.
`default_nettype none

module tb;

  import pcd_pkg::*;
  import pcd_tb_pkg::*;

  localparam int unsigned SETTLE_CYCLES = BITS_PER_WORD + 4;
  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned ITEMS_PER_MODE = 400;

  logic clk_i;
  logic rst_ni;

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned stall_left;
  int unsigned cycle_count;

  pcm_checker chk;

  pcd_word_if #(.W(BITS_PER_WORD)) pdm ();
  pcd_cfg_if                       cfg ();
  pcd_pcm_if                       pcm ();

  pdm_cic_decimator #(
    .STAGES        (STAGES),
    .BITS_PER_WORD (BITS_PER_WORD)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pdm_i  (pdm),
    .cfg_i  (cfg),
    .pcm_o  (pcm)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("** pdm_cic_decimator: FAILED **");
      $finish;
    end
  end

  // Sample the output request, then pick ready for the next cycle; stalls come in bursts.
  always @(posedge clk_i) begin
    if (rst_ni && pcm.valid && pcm.ready) chk.check_pcm(pcm.pcm_sample, pcm.block_end);
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      pcm.ready  <= 1'b0;
    end else if ($urandom_range(0, 99) < snk_stall_pct) begin
      stall_left <= $urandom_range(0, 2 * BITS_PER_WORD);
      pcm.ready  <= 1'b0;
    end else begin
      pcm.ready <= 1'b1;
    end
  end

  task automatic send_word(input pdm_word_t word);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      pdm.valid <= 1'b0;
      repeat ($urandom_range(1, 2 * BITS_PER_WORD)) @(posedge clk_i);
    end
    pdm.valid    <= 1'b1;
    pdm.pdm_word <= word;
    do @(posedge clk_i); while (!pdm.ready);
    chk.take_word(word);
  endtask

  // Drop valid, wait for every sample, then let the engine drain.
  task automatic settle();
    pdm.valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_block_length(input blk_len_t len);
    settle();
    cfg.valid        <= 1'b1;
    cfg.block_length <= len;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    chk.set_block_length(len);
  endtask

  function automatic pdm_word_t random_word();
    pdm_word_t   w;
    int unsigned density;
    case ($urandom_range(0, 3))
      0: begin
        // PDM-like stream: ones at a random density.
        density = $urandom_range(0, 100);
        for (int i = 0; i < BITS_PER_WORD; i++) w[i] = $urandom_range(0, 99) < density;
      end
      1: begin
        case ($urandom_range(0, 3))
          0: w = 16'h0000;
          1: w = 16'hFFFF;
          2: w = 16'hAAAA;
          default: w = 16'h5555;
        endcase
      end
      default: w = pdm_word_t'($urandom_range(0, 16'hFFFF));
    endcase
    return w;
  endfunction

  function automatic blk_len_t random_block_length();
    blk_len_t len;
    case ($urandom_range(0, 9))
      0: len = '0;
      1: len = 16'hFFFF;
      2: len = blk_len_t'($urandom_range(0, 16'hFFFF));
      default: len = blk_len_t'($urandom_range(1, 24));
    endcase
    return len;
  endfunction

  initial begin
    pdm_word_t   directed_words [$];
    int unsigned sent;
    int unsigned burst;

    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    pdm.valid        = 1'b0;
    pdm.pdm_word     = '0;
    cfg.valid        = 1'b0;
    cfg.block_length = '0;
    pcm.ready        = 1'b0;
    stall_left       = 0;
    cycle_count      = 0;
    src_idle_pct     = 10;
    snk_stall_pct    = 56;
    chk              = new();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes and alternating patterns at the reset block length.
    directed_words = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h0001, 16'hAAAA,
                       16'h5555, 16'h7FFF, 16'hFFFE, 16'h0000, 16'h0000, 16'hF0F0};
    foreach (directed_words[i]) send_word(directed_words[i]);

    // Zero length behaves like one: every sample ends a block.
    write_block_length(16'h0000);
    send_word(16'hFFFF);
    send_word(16'h0000);
    write_block_length(16'h0001);
    send_word(16'h1234);
    send_word(16'hEDCB);
    write_block_length(16'hFFFF);
    send_word(16'h8001);
    send_word(16'h7FFE);

    // Lower the length below the count reached mid-block.
    write_block_length(16'h0001);
    send_word(16'h0F0F);
    write_block_length(16'h0005);
    repeat (3) send_word(random_word());
    write_block_length(16'h0002);
    repeat (2) send_word(random_word());

    for (int mode = 0; mode < 3; mode++) begin
      settle();
      case (mode)
        0: begin
          src_idle_pct  = 10;
          snk_stall_pct = 56;
        end
        1: begin
          src_idle_pct  = 56;
          snk_stall_pct = 10;
        end
        default: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_MODE) begin
        write_block_length(random_block_length());
        burst = $urandom_range(10, 60);
        repeat (burst) send_word(random_word());
        sent += burst;
      end
    end

    settle();
    if (chk.clean()) begin
      $display("** pdm_cic_decimator: PASSED **");
    end else begin
      $display("** pdm_cic_decimator: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+hdl
hdl/pcd_pkg.sv
hdl/pcd_ifs.sv
hdl/pcd_front.sv
hdl/pcd_engine.sv
hdl/pdm_cic_decimator.sv
sim/pcd_tb_pkg.sv
sim/tb.sv
